// File: sv/sd_mmc_host_controller_top_macros.svh
// Assertion macros for the SD/MMC host controller.
`ifndef SD_MMC_HOST_CONTROLLER_TOP_MACROS_SVH
`define SD_MMC_HOST_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sd/mmc check failed");

// Next-cycle implication, checked out of reset.
`define SD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sd/mmc check failed");

`endif

// File: sv/sdmmc_pkg.sv
// Types and constants of the SD/MMC host controller.
package sdmmc_pkg;

  localparam int unsigned MAX_BLOCK_BYTES = 512;
  localparam int unsigned IN_W  = 80;
  localparam int unsigned OUT_W = 112;

  typedef enum logic [1:0] {
    ACC_RD16 = 2'd0,
    ACC_RD32 = 2'd1,
    ACC_WR16 = 2'd2,
    ACC_WR32 = 2'd3
  } access_e;

  typedef enum logic [2:0] {
    CS_IDLE  = 3'd0,
    CS_READY = 3'd1,
    CS_IDENT = 3'd2,
    CS_STBY  = 3'd3,
    CS_TRAN  = 3'd4,
    CS_DATA  = 3'd5,
    CS_RCV   = 3'd6,
    CS_PRG   = 3'd7
  } card_state_e;

  typedef enum logic [2:0] {
    XM_NONE     = 3'd0,
    XM_STATUS   = 3'd1,
    XM_SCR      = 3'd2,
    XM_RD_FLASH = 3'd3,
    XM_RD_CARD  = 3'd4,
    XM_WR_FLASH = 3'd5,
    XM_WR_CARD  = 3'd6
  } xfer_mode_e;

  // Register offsets, one bit wider than the window so off+2 cannot alias.
  localparam logic [9:0] OFF_CMD      = 10'h000;
  localparam logic [9:0] OFF_PORT     = 10'h002;
  localparam logic [9:0] OFF_ARG_LO   = 10'h004;
  localparam logic [9:0] OFF_ARG_HI   = 10'h006;
  localparam logic [9:0] OFF_BLKCNT   = 10'h00A;
  localparam logic [9:0] OFF_RESP     = 10'h00C;
  localparam logic [9:0] OFF_RESP_END = 10'h01C;
  localparam logic [9:0] OFF_IRQ_LO   = 10'h01C;
  localparam logic [9:0] OFF_IRQ_HI   = 10'h01E;
  localparam logic [9:0] OFF_MASK_LO  = 10'h020;
  localparam logic [9:0] OFF_MASK_HI  = 10'h022;
  localparam logic [9:0] OFF_BLKLEN   = 10'h026;
  localparam logic [9:0] OFF_FIFO     = 10'h030;
  localparam logic [9:0] OFF_CTRL     = 10'h0D8;
  localparam logic [9:0] OFF_VERSION  = 10'h0F8;
  localparam logic [9:0] OFF_D32_CTRL = 10'h100;
  localparam logic [9:0] OFF_D32_LEN  = 10'h104;
  localparam logic [9:0] OFF_D32_CNT  = 10'h108;
  localparam logic [9:0] OFF_FIFO32   = 10'h10C;

  localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0] CMD_SEND_OP  = 6'd1;
  localparam logic [5:0] CMD_ALL_CID  = 6'd2;
  localparam logic [5:0] CMD_REL_ADDR = 6'd3;
  localparam logic [5:0] CMD_SWITCH   = 6'd6;
  localparam logic [5:0] CMD_SELECT   = 6'd7;
  localparam logic [5:0] CMD_IF_COND  = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD = 6'd9;
  localparam logic [5:0] CMD_SEND_CID = 6'd10;
  localparam logic [5:0] CMD_STOP     = 6'd12;
  localparam logic [5:0] CMD_STATUS   = 6'd13;
  localparam logic [5:0] CMD_BLKLEN   = 6'd16;
  localparam logic [5:0] CMD_RD_MULTI = 6'd18;
  localparam logic [5:0] CMD_WR_MULTI = 6'd25;
  localparam logic [5:0] CMD_APP      = 6'd55;

  localparam logic [5:0] ACMD_BUS_WIDTH = 6'd6;
  localparam logic [5:0] ACMD_SD_STATUS = 6'd13;
  localparam logic [5:0] ACMD_OP_COND   = 6'd41;
  localparam logic [5:0] ACMD_CLR_DET   = 6'd42;
  localparam logic [5:0] ACMD_SEND_SCR  = 6'd51;

  localparam int unsigned D32_DATA32 = 0;
  localparam int unsigned D32_RD_PEND = 1;
  localparam int unsigned D32_TX_PEND = 2;
  localparam int unsigned D32_RD_EN = 3;
  localparam int unsigned D32_TX_EN = 4;

  localparam logic [31:0] ST_CMD_DONE = 32'h0000_0001;
  localparam logic [31:0] ST_XFER_END = 32'h0000_0004;
  localparam logic [31:0] ST_RD_READY = 32'h0100_0000;
  localparam logic [31:0] ST_WR_READY = 32'h0200_0000;

  localparam logic [31:0] OCR_WORD     = 32'h80FF_8080;
  localparam logic [31:0] OCR_HCS      = 32'h4000_0000;
  localparam logic [31:0] IF_COND_ECHO = 32'h0000_01AA;
  localparam logic [31:0] IDLE_REPLY   = 32'h0000_0200;
  localparam logic [31:0] RCA_REPLY    = 32'h0001_0000;
  localparam logic [31:0] SCR_WORD1    = 32'h012A_0000;
  localparam logic [15:0] VERSION_WORD = 16'h0004;
  localparam logic [15:0] IRQ_FIXED    = 16'h00A0;

  localparam logic [3:0][31:0] CSD_WORDS = {32'h3f26_9001, 32'h2a0f_5901,
                                           32'hdff6_db7f, 32'he996_4040};
  localparam logic [3:0][31:0] CID_WORDS = {32'h0015_0100, 32'h4D32_4731,
                                           32'h4445_147B, 32'hD71C_65CD};

  typedef struct packed {
    logic [31:0]       int_status;
    logic [31:0]       int_mask;
    logic [31:0]       cmd_argument;
    logic [3:0][31:0]  resp;
    logic [15:0]       port_sel;
    logic [15:0]       block_count;
    logic [9:0]        block_length;
    logic [15:0]       ctrl_word;
    logic [4:0]        d32_ctrl;
    logic [9:0]        d32_len;
    logic [15:0]       d32_count;
    card_state_e       card;
    logic              app;
    logic [9:0]        rem;
    logic [9:0]        pos;
    logic [15:0]       blocks_left;
    xfer_mode_e        mode;
    logic [40:0]       base;
    logic [1:0]        bus_width;
    logic              dma_lvl;
  } st_t;

  typedef struct packed {
    logic        err;
    logic        dmablk;
    logic        dma_req;
    logic        sel;
    logic [31:0] wdata;
    logic [40:0] addr;
    logic        mwr;
    logic        mrd;
    logic        irq;
    logic [31:0] rd;
  } res_t;

  typedef struct packed {
    st_t  st;
    res_t res;
  } ctx_t;

endpackage

// File: sv/sd_mmc_host_controller_top.sv
// SD/MMC host controller register window with an emulated card.
// The result word of each accepted bus word is registered in the output register.
// Throughput: one access per cycle while the output side accepts; all decode and state update sits
// between the register state and the output register, and a stalled output side holds back the input.
// Reset: all state, status and configuration clear; card goes idle, no transfer.
module sd_mmc_host_controller_top import sdmmc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [63:0]      cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // reg_offset[8:0], write_data[40:9], media_word[72:41], zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // read_data, irq_pulse, media_read, media_write, media_addr, media_wdata,
  // media_select, dma_read_req, dma_block_req, error
  output logic [OUT_W-1:0] m_axis_tdata
);

`include "sd_mmc_host_controller_top_macros.svh"

  logic [63:0] cid_lo_q, cid_hi_q;
  st_t         st_q;
  ctx_t        nxt;
  res_t        res_q;
  logic        out_valid_q;
  logic        acc;

  logic [1:0]  in_kind;
  logic [8:0]  in_off;
  logic [31:0] in_wdata;
  logic [31:0] media_word;

  assign in_kind    = s_axis_tuser;
  assign in_off     = s_axis_tdata[8:0];
  assign in_wdata   = s_axis_tdata[40:9];
  assign media_word = s_axis_tdata[72:41];

  function automatic ctx_t raise(ctx_t c, logic [31:0] bits);
    if (((c.st.int_status & c.st.int_mask & bits) == '0) && ((c.st.int_mask & bits) != '0))
      c.res.irq = 1'b1;
    c.st.int_status = c.st.int_status | bits;
    return c;
  endfunction

  function automatic logic [31:0] r1(ctx_t c);
    return 32'({c.st.card, (c.st.rem == '0), 2'b00, c.st.app, 5'b0});
  endfunction

  function automatic ctx_t rd_word_avail(ctx_t c);
    c.st.d32_ctrl[D32_TX_PEND] = 1'b0;
    c.st.d32_ctrl[D32_RD_PEND] = 1'b1;
    if (c.st.d32_ctrl[D32_RD_EN]) c = raise(c, ST_RD_READY);
    c.st.dma_lvl = 1'b1;
    return c;
  endfunction

  function automatic ctx_t wr_word_avail(ctx_t c);
    c.st.d32_ctrl[D32_TX_PEND] = 1'b0;
    c.st.d32_ctrl[D32_RD_PEND] = 1'b0;
    if (c.st.d32_ctrl[D32_TX_EN]) c = raise(c, ST_WR_READY);
    return c;
  endfunction

  function automatic ctx_t xfer_finish(ctx_t c);
    c.st.mode = XM_NONE;
    c.st.d32_ctrl[D32_RD_PEND] = 1'b0;
    c.st.card = (c.st.card == CS_DATA || c.st.card == CS_RCV) ? CS_TRAN : CS_STBY;
    c.st.int_status[0] = 1'b0;
    c = raise(c, ST_XFER_END);
    c = raise(c, ST_CMD_DONE);
    c.st.dma_lvl = 1'b0;
    return c;
  endfunction

  function automatic ctx_t media_access(ctx_t c);
    c.res.addr = c.st.base + {31'b0, c.st.pos[9:2], 2'b00};
    c.res.sel  = (c.st.mode == XM_RD_CARD || c.st.mode == XM_WR_CARD);
    return c;
  endfunction

  function automatic ctx_t fetch(ctx_t c, output logic [31:0] w);
    if (c.st.mode == XM_STATUS) begin
      w = (c.st.pos[5:2] == 4'hF) ? {c.st.bus_width, 30'b0} : '0;
    end else if (c.st.mode == XM_SCR) begin
      w = c.st.pos[2] ? SCR_WORD1 : '0;
    end else begin
      c = media_access(c);
      c.res.mrd = 1'b1;
      w = media_word;
    end
    return c;
  endfunction

  function automatic logic read_mode(ctx_t c);
    return c.st.mode >= XM_STATUS && c.st.mode <= XM_RD_CARD;
  endfunction

  function automatic ctx_t next_block(ctx_t c, logic [9:0] consumed, logic writing);
    c.st.blocks_left = c.st.blocks_left - 16'd1;
    if (c.st.blocks_left == '0) begin
      c = xfer_finish(c);
    end else begin
      c.res.dmablk = 1'b1;
      c.st.rem  = c.st.block_length;
      c.st.base = c.st.base + {31'b0, consumed};
      if (writing) c = wr_word_avail(c);
    end
    return c;
  endfunction

  function automatic ctx_t fifo_read16(ctx_t c);
    logic [31:0] w;
    if (c.st.rem != '0 && read_mode(c)) begin
      c = fetch(c, w);
      c.res.rd = c.st.pos[1] ? {16'b0, w[31:16]} : {16'b0, w[15:0]};
      c.st.pos = c.st.pos + 10'd2;
      c.st.rem = (c.st.rem > 10'd2) ? c.st.rem - 10'd2 : '0;
      if (c.st.rem == '0) c = xfer_finish(c);
    end
    return c;
  endfunction

  function automatic ctx_t fifo_read32(ctx_t c);
    logic [31:0] w;
    logic [9:0]  consumed;
    if (c.st.rem != '0 && read_mode(c)) begin
      c = fetch(c, w);
      c.res.rd = w;
      c.st.pos = c.st.pos + 10'd4;
      c.st.rem = (c.st.rem > 10'd4) ? c.st.rem - 10'd4 : '0;
      if (c.st.rem == '0) begin
        consumed = c.st.pos;
        c = rd_word_avail(c);
        c.st.pos = '0;
        if (c.st.mode == XM_RD_FLASH || c.st.mode == XM_RD_CARD)
          c = next_block(c, consumed, 1'b0);
        else
          c = xfer_finish(c);
      end
    end
    return c;
  endfunction

  function automatic ctx_t fifo_write32(ctx_t c, logic [31:0] v);
    logic [9:0] consumed;
    if (c.st.rem != '0 && (c.st.mode == XM_WR_FLASH || c.st.mode == XM_WR_CARD)) begin
      c = media_access(c);
      c.res.mwr   = 1'b1;
      c.res.wdata = v;
      c.st.pos = c.st.pos + 10'd4;
      c.st.rem = (c.st.rem > 10'd4) ? c.st.rem - 10'd4 : '0;
      if (c.st.rem == '0) begin
        consumed = c.st.pos;
        c.st.pos = '0;
        c = next_block(c, consumed, 1'b1);
      end
    end
    return c;
  endfunction

  function automatic ctx_t start_blocks(ctx_t c, logic writing);
    logic        flash;
    logic [41:0] prod;
    flash = c.st.port_sel[0];
    c.st.card = CS_TRAN;
    c.st.resp[0] = r1(c);
    c.st.card = writing ? CS_RCV : CS_DATA;
    c.st.pos = '0;
    c.st.blocks_left = c.st.block_count;
    c.st.rem = c.st.block_length;
    prod = c.st.cmd_argument * c.st.block_length;
    c.st.base = flash ? {9'b0, c.st.cmd_argument} : prod[40:0];
    if (writing) begin
      c.st.mode = flash ? XM_WR_FLASH : XM_WR_CARD;
      c = wr_word_avail(c);
    end else begin
      c.st.mode = flash ? XM_RD_FLASH : XM_RD_CARD;
      c = rd_word_avail(c);
    end
    return c;
  endfunction

  function automatic ctx_t run_cmd(ctx_t c, logic [5:0] code);
    case (code)
      CMD_GO_IDLE: begin
        c.st.int_status = '0;
        c.st.resp[0] = IDLE_REPLY;
        c = raise(c, ST_CMD_DONE);
        c.st.card = CS_IDLE;
      end
      CMD_SEND_OP: begin
        c.st.resp[0] = OCR_WORD;
        c = raise(c, ST_CMD_DONE);
      end
      CMD_ALL_CID: begin
        c.st.resp = c.st.port_sel[0] ? {cid_hi_q, cid_lo_q} : CID_WORDS;
        c = raise(c, ST_CMD_DONE);
        if (c.st.card == CS_READY) c.st.card = CS_IDENT;
      end
      CMD_REL_ADDR: begin
        c.st.resp[0] = RCA_REPLY | r1(c);
        c = raise(c, ST_CMD_DONE);
        if (c.st.card == CS_IDENT) c.st.card = CS_STBY;
      end
      CMD_SWITCH: begin
        c.st.resp[0] = r1(c);
        c = raise(c, ST_CMD_DONE);
        if (c.st.card == CS_TRAN) c.st.card = CS_PRG;
      end
      CMD_SELECT, CMD_STATUS: begin
        c.st.resp[0] = r1(c);
        c = raise(c, ST_CMD_DONE);
      end
      CMD_IF_COND: begin
        c.st.resp[0] = IF_COND_ECHO;
        c = raise(c, ST_CMD_DONE);
      end
      CMD_SEND_CSD: begin
        c.st.resp = CSD_WORDS;
        c = raise(c, ST_CMD_DONE);
      end
      CMD_SEND_CID: begin
        c.st.resp = {cid_hi_q, cid_lo_q};
        c = raise(c, ST_CMD_DONE);
      end
      CMD_STOP: begin
        c.st.resp[0] = r1(c);
        c.st.rem = '0;
        c = xfer_finish(c);
        if (c.st.card == CS_TRAN) c.st.card = CS_STBY;
      end
      CMD_BLKLEN:   c = raise(c, ST_CMD_DONE);
      CMD_RD_MULTI: c = start_blocks(c, 1'b0);
      CMD_WR_MULTI: c = start_blocks(c, 1'b1);
      CMD_APP: begin
        c.st.app = 1'b1;
        c.st.resp[0] = r1(c);
        c = raise(c, ST_CMD_DONE);
      end
      default: c.res.err = 1'b1;
    endcase
    return c;
  endfunction

  function automatic ctx_t run_acmd(ctx_t c, logic [5:0] code);
    c.st.int_status[0] = 1'b0;
    c.st.app = 1'b0;
    case (code)
      ACMD_BUS_WIDTH: begin
        c.st.bus_width = c.st.cmd_argument[1:0];
        c.st.resp[0] = r1(c);
        c = raise(c, ST_CMD_DONE);
      end
      ACMD_SD_STATUS, ACMD_SEND_SCR: begin
        c.st.resp[0] = r1(c);
        c.st.d32_ctrl[D32_RD_PEND] = 1'b1;
        c = raise(c, ST_RD_READY);
        c.st.mode = (code == ACMD_SD_STATUS) ? XM_STATUS : XM_SCR;
        c.st.pos = '0;
        c.st.rem = (code == ACMD_SD_STATUS) ? 10'd64 : 10'd8;
        c = raise(c, ST_CMD_DONE);
        if (code == ACMD_SEND_SCR) c = rd_word_avail(c);
      end
      ACMD_OP_COND: begin
        c.st.resp[0] = c.st.port_sel[0] ? OCR_WORD : (OCR_WORD | OCR_HCS);
        c = raise(c, ST_CMD_DONE);
        if (c.st.card == CS_IDLE) c.st.card = CS_READY;
      end
      ACMD_CLR_DET: begin
        c.st.resp[0] = r1(c);
        c = raise(c, ST_CMD_DONE);
      end
      default: c.res.err = 1'b1;
    endcase
    return c;
  endfunction

  function automatic ctx_t read16(ctx_t c, logic [9:0] off);
    logic [9:0]  roff;
    logic [31:0] w;
    roff = off - OFF_RESP;
    w = c.st.resp[roff[3:2]];
    if (off >= OFF_RESP && off < OFF_RESP_END) begin
      c.res.rd = (off[1:0] == 2'd2) ? {16'b0, w[31:16]} : {16'b0, w[15:0]};
    end else begin
      unique case (off)
        OFF_PORT:    c.res.rd = {16'b0, c.st.port_sel};
        OFF_BLKCNT:  c.res.rd = {16'b0, c.st.block_count};
        OFF_IRQ_LO:  c.res.rd = {16'b0, c.st.int_status[15:0] | IRQ_FIXED};
        OFF_IRQ_HI:  c.res.rd = {16'b0, c.st.int_status[31:16]};
        OFF_MASK_LO: c.res.rd = {16'b0, c.st.int_mask[15:0]};
        OFF_MASK_HI: c.res.rd = {16'b0, c.st.int_mask[31:16]};
        OFF_BLKLEN:  c.res.rd = {22'b0, c.st.block_length};
        OFF_FIFO:    c = fifo_read16(c);
        OFF_CTRL:    c.res.rd = {16'b0, c.st.ctrl_word};
        OFF_VERSION: c.res.rd = {16'b0, VERSION_WORD};
        OFF_D32_CTRL:
          c.res.rd = 32'({c.st.d32_ctrl[D32_TX_EN], c.st.d32_ctrl[D32_RD_EN], 1'b0,
                          c.st.d32_ctrl[D32_TX_PEND], c.st.d32_ctrl[D32_RD_PEND], 6'b0,
                          c.st.d32_ctrl[D32_DATA32], 1'b0});
        OFF_D32_LEN: c.res.rd = {22'b0, c.st.d32_len};
        default:     c.res.rd = '0;
      endcase
    end
    return c;
  endfunction

  function automatic ctx_t write16(ctx_t c, logic [9:0] off, logic [15:0] v);
    unique case (off)
      OFF_CMD:     c = c.st.app ? run_acmd(c, v[5:0]) : run_cmd(c, v[5:0]);
      OFF_PORT:    c.st.port_sel = v;
      OFF_ARG_LO:  c.st.cmd_argument[15:0] = v;
      OFF_ARG_HI:  c.st.cmd_argument[31:16] = v;
      OFF_BLKCNT:  c.st.block_count = v;
      OFF_IRQ_LO:  c.st.int_status[15:0] = c.st.int_status[15:0] & v;
      OFF_IRQ_HI:  c.st.int_status[31:16] = c.st.int_status[31:16] & v;
      OFF_MASK_LO: c.st.int_mask[15:0] = v;
      OFF_MASK_HI: c.st.int_mask[31:16] = v;
      OFF_BLKLEN:
        c.st.block_length = ({16'b0, v} > 32'(MAX_BLOCK_BYTES)) ? 10'(MAX_BLOCK_BYTES) : v[9:0];
      OFF_CTRL:    c.st.ctrl_word = v;
      OFF_D32_CTRL: begin
        c.st.d32_ctrl[D32_DATA32] = v[1];
        c.st.d32_ctrl[D32_RD_EN]  = v[11];
        c.st.d32_ctrl[D32_TX_EN]  = v[12];
      end
      OFF_D32_LEN: c.st.d32_len = v[9:0];
      OFF_D32_CNT: c.st.d32_count = v;
      default: ;
    endcase
    return c;
  endfunction

  always_comb begin
    logic [9:0] off;
    off = {1'b0, in_off};
    nxt.st  = st_q;
    nxt.res = '0;
    case (in_kind)
      ACC_RD16: nxt = read16(nxt, off);
      ACC_RD32: begin
        if (off == OFF_IRQ_LO) nxt.res.rd = nxt.st.int_status | {16'b0, IRQ_FIXED};
        else if (off == OFF_FIFO32) nxt = fifo_read32(nxt);
        else nxt.res.err = 1'b1;
      end
      ACC_WR16: nxt = write16(nxt, off, in_wdata[15:0]);
      default: begin
        if (off == OFF_FIFO32) begin
          nxt = fifo_write32(nxt, in_wdata);
        end else begin
          nxt = write16(nxt, off, in_wdata[15:0]);
          nxt = write16(nxt, off + 10'd2, in_wdata[31:16]);
        end
      end
    endcase
    nxt.res.dma_req = nxt.st.dma_lvl;
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q.err, res_q.dmablk, res_q.dma_req, res_q.sel, res_q.wdata,
                          res_q.addr, res_q.mwr, res_q.mrd, res_q.irq, res_q.rd};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cid_lo_q <= '0;
      cid_hi_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i) cid_hi_q <= cfg_data_i;
      else cid_lo_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) st_q <= nxt.st;
      if (acc) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) res_q <= nxt.res;
  end

  `SD_ASSERT_IMP(a_no_rd_wr_same_word, out_valid_q, !(res_q.mrd && res_q.mwr))
  `SD_ASSERT_IMP(a_err_no_media, out_valid_q && res_q.err, !res_q.mrd && !res_q.mwr)
  `SD_ASSERT_IMP(a_idle_xfer_empty, st_q.mode == XM_NONE, st_q.rem == '0)
  `SD_ASSERT_NXT(a_acmd_clears_app,
    acc && st_q.app && in_off == OFF_CMD[8:0] && (in_kind == ACC_WR16 || in_kind == ACC_WR32),
    !st_q.app)

endmodule
